// ===== design/tcw_pkg.sv =====
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int unsigned ACT_W = 3;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ROW_W = 5;
  localparam int unsigned COL_W = 7;
  localparam int unsigned CLR_W = 4;
  localparam int unsigned DATA_W = 16;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_LSB = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUT        = 3'd0,
    ACT_PUT_AT     = 3'd1,
    ACT_SET_CURSOR = 3'd2,
    ACT_NEWLINE    = 3'd3,
    ACT_CLEAR      = 3'd4,
    ACT_CLEAR_ROW  = 3'd5,
    ACT_ADVANCE    = 3'd6,
    ACT_READ       = 3'd7
  } action_e;

  typedef enum logic [APB_ADDR_W-REG_IDX_LSB-1:0] {
    REG_ENABLED = 2'd0,
    REG_TEXT_FG = 2'd1,
    REG_TEXT_BG = 2'd2
  } reg_idx_e;

  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  localparam logic [CLR_W-1:0] FG_RESET = 4'hF;
  localparam logic [CLR_W-1:0] BG_RESET = 4'h0;

  typedef struct packed {
    logic             enabled;
    logic [CLR_W-1:0] fg;
    logic [CLR_W-1:0] bg;
  } cfg_t;

  typedef struct packed {
    action_e           action;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic [CLR_W-1:0]  cell_fg;
    logic [CLR_W-1:0]  cell_bg;
  } item_t;

  typedef struct packed {
    logic [ROW_W-1:0]  out_row;
    logic [COL_W-1:0]  out_col;
    logic              wrapped;
    logic [DATA_W-1:0] cell_data;
  } result_t;

  typedef struct packed {
    logic init_wr;
    logic load;
    logic exec;
    logic copy;
    logic blank;
    logic put_wr;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic scroll;
    logic put_after;
    logic sweep;
    logic last;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== design/tcw_item_if.sv =====
`timescale 1ns / 1ps

interface tcw_item_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  action_e           action;
  logic [CHAR_W-1:0] char_code;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  column;
  logic [CLR_W-1:0]  cell_fg;
  logic [CLR_W-1:0]  cell_bg;

  modport source (
    output valid, action, char_code, row, column, cell_fg, cell_bg,
    input  ready
  );

  modport sink (
    input  valid, action, char_code, row, column, cell_fg, cell_bg,
    output ready
  );
endinterface

// ===== design/tcw_result_if.sv =====
`timescale 1ns / 1ps

interface tcw_result_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  out_row;
  logic [COL_W-1:0]  out_col;
  logic              wrapped;
  logic [DATA_W-1:0] cell_data;

  modport source (
    output valid, out_row, out_col, wrapped, cell_data,
    input  ready
  );

  modport sink (
    input  valid, out_row, out_col, wrapped, cell_data,
    output ready
  );
endinterface

// ===== design/text_console_cell_writer.sv =====
`timescale 1ns / 1ps
// a put from a pending wrap writes its cell in an extra state before the result is emitted
// the next item is taken while the result is delivered, unless the result output is stalled
// scroll: copy up, blank last row, one cell copied or blanked per cycle on the store port
// clear screen: every cell blanked, clear row: the addressed row blanked
// reset: async active low, then a clearing pass zeroes the store,
// no item accepted meanwhile (register writes still taken)

module text_console_cell_writer import tcw_pkg::*; #(
  parameter int unsigned ROWS      = 25,
  parameter int unsigned COLS      = 80,
  parameter int unsigned TAB_WIDTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tcw_item_if.sink              item_i,
  tcw_result_if.source          result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t       cfg;
  item_t      item;
  dp_cmd_t    cmd;
  dp_status_t status;
  result_t    res;

  assign pready = 1'b1;

  assign item = '{
    action:    item_i.action,
    char_code: item_i.char_code,
    row:       item_i.row,
    column:    item_i.column,
    cell_fg:   item_i.cell_fg,
    cell_bg:   item_i.cell_bg
  };

  tcw_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tcw_dp #(
    .ROWS      (ROWS),
    .COLS      (COLS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .item_i      (item),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_ready_i (result_o.ready),
    .res_valid_o (result_o.valid),
    .res_o       (res)
  );

  assign result_o.out_row   = res.out_row;
  assign result_o.out_col   = res.out_col;
  assign result_o.wrapped   = res.wrapped;
  assign result_o.cell_data = res.cell_data;

endmodule

// ===== design/tcw_cfg.sv =====
`timescale 1ns / 1ps

module tcw_cfg import tcw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  output logic [APB_DATA_W-1:0] prdata_o,
  output cfg_t                  cfg_o
);

  logic                                enabled_q;
  logic [CLR_W-1:0]                    fg_q;
  logic [CLR_W-1:0]                    bg_q;
  logic                                wr_en;
  logic [APB_ADDR_W-REG_IDX_LSB-1:0]   reg_idx;

  assign wr_en   = psel_i && penable_i && pwrite_i;
  assign reg_idx = paddr_i[APB_ADDR_W-1:REG_IDX_LSB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      fg_q      <= FG_RESET;
      bg_q      <= BG_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ENABLED: enabled_q <= pwdata_i[0];
        REG_TEXT_FG: fg_q      <= pwdata_i[CLR_W-1:0];
        REG_TEXT_BG: bg_q      <= pwdata_i[CLR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata_o = '0;
    unique case (reg_idx)
      REG_ENABLED: prdata_o[0]         = enabled_q;
      REG_TEXT_FG: prdata_o[CLR_W-1:0] = fg_q;
      REG_TEXT_BG: prdata_o[CLR_W-1:0] = bg_q;
      default: ;
    endcase
  end

  assign cfg_o = '{enabled: enabled_q, fg: fg_q, bg: bg_q};

endmodule

// ===== design/tcw_ctrl.sv =====
`timescale 1ns / 1ps

module tcw_ctrl import tcw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_COPY,
    ST_DRAIN,
    ST_BLANK,
    ST_PUTW,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   put_pend_q, put_pend_d;

  always_comb begin
    state_d    = state_q;
    put_pend_d = put_pend_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (status_i.last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.exec = 1'b1;
        put_pend_d = status_i.put_after;
        if (status_i.scroll) begin
          state_d = ST_COPY;
        end else if (status_i.put_after) begin
          state_d = ST_PUTW;
        end else if (status_i.sweep) begin
          state_d = ST_BLANK;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_COPY: begin
        cmd_o.copy = 1'b1;
        if (status_i.last) begin
          state_d = ST_DRAIN;
        end
      end
      // last copied cell is written here
      ST_DRAIN: begin
        state_d = ST_BLANK;
      end
      ST_BLANK: begin
        cmd_o.blank = 1'b1;
        if (status_i.last) begin
          state_d = put_pend_q ? ST_PUTW : ST_DONE;
        end
      end
      ST_PUTW: begin
        cmd_o.put_wr = 1'b1;
        put_pend_d   = 1'b0;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            state_d    = ST_DECODE;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      put_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      put_pend_q <= put_pend_d;
    end
  end

endmodule

// ===== design/tcw_dp.sv =====
`timescale 1ns / 1ps

module tcw_dp import tcw_pkg::*; #(
  parameter int unsigned ROWS      = 25,
  parameter int unsigned COLS      = 80,
  parameter int unsigned TAB_WIDTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  item_t      item_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  input  logic       res_ready_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  localparam int unsigned NCELL = ROWS * COLS;
  localparam int unsigned AW    = $clog2(NCELL);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLS + 1);
  localparam int unsigned TSW   = $clog2(COLS + TAB_WIDTH + 1);
  localparam int unsigned NSTOP = COLS / TAB_WIDTH + 1;
  localparam logic [AW-1:0] LAST_ROW_BASE = AW'((ROWS - 1) * COLS);
  localparam logic [AW-1:0] COPY_LAST     = AW'((ROWS - 1) * COLS - 1);
  localparam logic [AW-1:0] LAST_CELL     = AW'(NCELL - 1);

  // cell store
  logic [DATA_W-1:0] mem_q [NCELL];
  logic [DATA_W-1:0] rdata_q;

  item_t             item_q;
  logic [RW-1:0]     cur_line_q, cur_line_d;
  logic [CW-1:0]     cur_col_q, cur_col_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [AW-1:0]     end_q, end_d;
  logic [AW-1:0]     cp_addr_q;
  logic              cp_vld_q;
  logic              wrapped_q;
  logic              rd_ok_q;
  logic              res_valid_q;
  result_t           res_q;

  logic              en;
  logic              is_put, is_lf, is_cr, is_tab, is_prn;
  logic              tab_brk, prn_brk, adv_brk, nl_brk, brk, scroll;
  logic              tgt_ok, clr_all, clr_row, put_now, putat_ok, rd_hit, last;
  logic [TSW-1:0]    tab_stop;
  logic [CW:0]       col_inc;
  logic [AW-1:0]     tgt_addr, cur_addr, row_base;
  logic [DATA_W-1:0] put_cell, blank_cell, putat_cell;
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata;

  assign en      = cfg_i.enabled;
  assign is_put  = (item_q.action == ACT_PUT) && en;
  assign is_lf   = is_put && (item_q.char_code == CHAR_LF);
  assign is_cr   = is_put && (item_q.char_code == CHAR_CR);
  assign is_tab  = is_put && (item_q.char_code == CHAR_TAB);
  assign is_prn  = is_put && !is_lf && !is_cr && !is_tab;
  assign col_inc = (CW + 1)'(cur_col_q) + (CW + 1)'(1);

  // next tab stop above the cursor
  always_comb begin
    tab_stop = TSW'(NSTOP * TAB_WIDTH);
    for (int k = NSTOP - 1; k >= 1; k--) begin
      if (cur_col_q < k * TAB_WIDTH) begin
        tab_stop = TSW'(k * TAB_WIDTH);
      end
    end
  end

  assign tab_brk = is_tab && (tab_stop >= COLS);
  assign prn_brk = is_prn && (cur_col_q >= COLS);
  assign adv_brk = (item_q.action == ACT_ADVANCE) && (col_inc >= COLS);
  assign nl_brk  = (item_q.action == ACT_NEWLINE) && en;
  assign brk     = is_lf || tab_brk || prn_brk || adv_brk || nl_brk;
  assign scroll  = brk && (cur_line_q == RW'(ROWS - 1));

  assign tgt_ok   = (item_q.row < ROWS) && (item_q.column < COLS);
  assign clr_all  = (item_q.action == ACT_CLEAR) && en;
  assign clr_row  = (item_q.action == ACT_CLEAR_ROW) && en && (item_q.row < ROWS);
  assign put_now  = is_prn && !prn_brk;
  assign putat_ok = (item_q.action == ACT_PUT_AT) && tgt_ok;
  assign rd_hit   = (item_q.action == ACT_READ) && tgt_ok;
  assign last     = (addr_q == end_q);

  assign row_base = AW'(item_q.row * COLS);
  assign tgt_addr = AW'(item_q.row * COLS + item_q.column);
  assign cur_addr = AW'(cur_line_q * COLS + cur_col_q);

  assign put_cell   = {cfg_i.bg, cfg_i.fg, item_q.char_code};
  assign blank_cell = {cfg_i.bg, cfg_i.fg, CHAR_SPACE};
  assign putat_cell = {item_q.cell_bg, item_q.cell_fg, item_q.char_code};

  // cursor
  always_comb begin
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    if (cmd_i.exec) begin
      unique case (item_q.action)
        ACT_PUT: begin
          if (is_cr) begin
            cur_col_d = '0;
          end else if (is_tab && !tab_brk) begin
            cur_col_d = CW'(tab_stop);
          end else if (put_now) begin
            cur_col_d = CW'(col_inc);
          end
        end
        ACT_SET_CURSOR: begin
          cur_col_d  = (item_q.column >= COLS) ? CW'(COLS - 1) : CW'(item_q.column);
          cur_line_d = (item_q.row >= ROWS) ? RW'(ROWS - 1) : RW'(item_q.row);
        end
        ACT_CLEAR: begin
          if (en) begin
            cur_col_d  = '0;
            cur_line_d = '0;
          end
        end
        ACT_ADVANCE: begin
          if (!adv_brk) begin
            cur_col_d = CW'(col_inc);
          end
        end
        default: ;
      endcase
      if (brk) begin
        cur_col_d = '0;
        if (!scroll) begin
          cur_line_d = RW'(cur_line_q + 1'b1);
        end
      end
    end
    if (cmd_i.put_wr) begin
      cur_col_d = CW'(col_inc);
    end
  end

  // sweep address range
  always_comb begin
    addr_d = addr_q;
    end_d  = end_q;
    if (cmd_i.init_wr || cmd_i.blank) begin
      addr_d = AW'(addr_q + 1'b1);
    end
    if (cmd_i.copy) begin
      addr_d = AW'(addr_q + 1'b1);
      if (last) begin
        addr_d = LAST_ROW_BASE;
        end_d  = LAST_CELL;
      end
    end
    if (cmd_i.exec) begin
      if (scroll) begin
        addr_d = '0;
        end_d  = COPY_LAST;
      end else if (clr_all) begin
        addr_d = '0;
        end_d  = LAST_CELL;
      end else if (clr_row) begin
        addr_d = row_base;
        end_d  = AW'(row_base + COLS - 1);
      end
    end
  end

  // single write port
  always_comb begin
    we    = 1'b0;
    waddr = addr_q;
    wdata = '0;
    if (cp_vld_q) begin
      we    = 1'b1;
      waddr = cp_addr_q;
      wdata = rdata_q;
    end else if (cmd_i.init_wr) begin
      we    = 1'b1;
    end else if (cmd_i.blank) begin
      we    = 1'b1;
      wdata = blank_cell;
    end else if (cmd_i.put_wr || (cmd_i.exec && put_now)) begin
      we    = 1'b1;
      waddr = cur_addr;
      wdata = put_cell;
    end else if (cmd_i.exec && putat_ok) begin
      we    = 1'b1;
      waddr = tgt_addr;
      wdata = putat_cell;
    end
  end

  assign re    = cmd_i.copy || (cmd_i.exec && rd_hit);
  assign raddr = cmd_i.copy ? AW'(addr_q + COLS) : tgt_addr;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_line_q  <= '0;
      cur_col_q   <= '0;
      addr_q      <= '0;
      end_q       <= LAST_CELL;
      cp_vld_q    <= 1'b0;
      wrapped_q   <= 1'b0;
      rd_ok_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      addr_q     <= addr_d;
      end_q      <= end_d;
      cp_vld_q   <= cmd_i.copy;
      if (cmd_i.emit) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        wrapped_q <= 1'b0;
        rd_ok_q   <= 1'b0;
      end else if (cmd_i.exec) begin
        wrapped_q <= brk;
        rd_ok_q   <= rd_hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.copy) begin
      cp_addr_q <= addr_q;
    end
    if (cmd_i.emit) begin
      res_q.out_row   <= ROW_W'(cur_line_q);
      res_q.out_col   <= COL_W'(cur_col_q);
      res_q.wrapped   <= wrapped_q;
      res_q.cell_data <= rd_ok_q ? rdata_q : '0;
    end
  end

  assign status_o = '{
    scroll:    scroll,
    put_after: prn_brk,
    sweep:     clr_all || clr_row,
    last:      last,
    out_busy:  res_valid_q && !res_ready_i
  };

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== design/tcw_checker.sv =====
`timescale 1ns / 1ps

module tcw_checker import tcw_pkg::*; #(
  parameter int unsigned ROWS = 25,
  parameter int unsigned COLS = 80
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  res_valid_i,
  input logic                  res_ready_i,
  input logic [ROW_W-1:0]      out_row_i,
  input logic [COL_W-1:0]      out_col_i,
  input logic                  wrapped_i,
  input logic [DATA_W-1:0]     cell_data_i,
  input logic                  psel_i,
  input logic                  pwrite_i,
  input logic [APB_ADDR_W-1:0] paddr_i,
  input logic [APB_DATA_W-1:0] prdata_i
);

  // stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(out_row_i) && $stable(out_col_i)
      && $stable(wrapped_i) && $stable(cell_data_i))
    else $error("result changed while stalled");

  // a line break leaves the cursor at the row start, or one past it after a put
  a_wrap_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && wrapped_i |-> out_col_i <= COL_W'(1))
    else $error("wrapped result with cursor beyond column one");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (out_row_i < ROWS) && (out_col_i <= COLS))
    else $error("cursor outside the screen");

  a_enable_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel_i && !pwrite_i && (paddr_i[APB_ADDR_W-1:REG_IDX_LSB] == REG_ENABLED)
      |-> prdata_i[APB_DATA_W-1:1] == '0)
    else $error("enable register reads back more than one bit");

endmodule

bind text_console_cell_writer tcw_checker #(
  .ROWS (ROWS),
  .COLS (COLS)
) u_tcw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (result_o.valid),
  .res_ready_i (result_o.ready),
  .out_row_i   (result_o.out_row),
  .out_col_i   (result_o.out_col),
  .wrapped_i   (result_o.wrapped),
  .cell_data_i (result_o.cell_data),
  .psel_i      (psel),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr),
  .prdata_i    (prdata)
);
